/* sv/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// Register indexes, result word layout and the handshake structs that run
// between the front end, the result queue and the top level.
// ----------------------------------------------------------------------------
package wbps_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd5;

	// pattern storage is fixed by the register map: 4 words of 8 bytes
	localparam int PAT_WORDS   = 4;
	localparam int PAT_BYTES   = 32;
	localparam int PAT_IDX_W   = 5;
	localparam int WILD_W      = 32;
	localparam int LEN_W       = 6;
	localparam int MATCH_OFF_W = 32;

	// result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	typedef struct packed {
		logic                   found;
		logic [MATCH_OFF_W-1:0] match_offset;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} result_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

/* sv/wbps_front.sv */
// ----------------------------------------------------------------------------
// wbps_front: byte intake, sliding window and pattern compare
// Holds the configuration, shifts each accepted byte into the window, counts
// the bytes of the image and, in the compare stage that follows, classifies
// the byte as match, not-found or silent; all but silent queue a result word.
// ----------------------------------------------------------------------------
module wbps_front
	import wbps_pkg::*;
#(
	parameter int MAX_PATTERN = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            image_byte,
	input  logic                  final_byte,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  queue_status_t         q_status,
	output result_wr_t            res_wr
);

	// configuration registers
	logic [CFG_DATA_W-1:0] pat_q [PAT_WORDS];
	logic [WILD_W-1:0]     wild_q;
	logic [LEN_W-1:0]      len_q;

	// pattern aligned to window positions
	logic [MAX_PATTERN-1:0] care_c, care_q;
	logic [7:0]             pa_c [MAX_PATTERN];
	logic [7:0]             pa_q [MAX_PATTERN];
	logic [LEN_W-1:0]       len_eff;
	logic [PAT_BYTES*8-1:0] pat_flat;

	// image state
	logic [7:0]             win_q [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] count_q;
	logic                   clear_pend_q;
	logic                   reported_q;

	// compare stage
	logic valid_s1, last_s1, sat_s1;

	logic                   accept, advance;
	logic [MAX_PATTERN-1:0] eq;
	logic                   match_all, len_ok, hit;
	logic [OFFSET_BITS-1:0] off_raw;
	logic [63:0]            off_wide;
	logic [MATCH_OFF_W-1:0] off_clamp;

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < PAT_WORDS; w++) pat_q[w] <= '0;
			wild_q <= '0;
			len_q  <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_0:    pat_q[0] <= cfg_data;
				REG_PAT_1:    pat_q[1] <= cfg_data;
				REG_PAT_2:    pat_q[2] <= cfg_data;
				REG_PAT_3:    pat_q[3] <= cfg_data;
				REG_WILDCARD: wild_q   <= cfg_data[WILD_W-1:0];
				REG_LENGTH:   len_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the length into 1..MAX_PATTERN
	always_comb begin
		if (len_q == '0)
			len_eff = LEN_W'(1);
		else if (len_q > LEN_W'(MAX_PATTERN))
			len_eff = LEN_W'(MAX_PATTERN);
		else
			len_eff = len_q;
	end

	// map pattern byte len-1-i onto window slot i (slot 0 = newest byte)
	assign pat_flat = {pat_q[3], pat_q[2], pat_q[1], pat_q[0]};

	always_comb begin
		logic [PAT_IDX_W-1:0] k;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			k         = PAT_IDX_W'(len_eff - LEN_W'(1) - LEN_W'(i));
			care_c[i] = (LEN_W'(i) < len_eff) && !wild_q[k];
			pa_c[i]   = pat_flat[{k, 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk) begin
		care_q <= care_c;
		for (int i = 0; i < MAX_PATTERN; i++) pa_q[i] <= pa_c[i];
	end

	// handshake: hold the compare stage while the queue is full
	assign advance = valid_s1 && !q_status.full;
	assign full    = valid_s1 && q_status.full;
	assign accept  = push && !full;

	// shift the window
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q[0] <= image_byte;
			for (int i = 1; i < MAX_PATTERN; i++) win_q[i] <= win_q[i-1];
		end
	end

	// count bytes of the image, restart after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			clear_pend_q <= 1'b0;
			valid_s1     <= 1'b0;
			last_s1      <= 1'b0;
			sat_s1       <= 1'b0;
		end else begin
			if (accept) begin
				clear_pend_q <= final_byte;
				last_s1      <= final_byte;
				if (clear_pend_q) begin
					count_q <= OFFSET_BITS'(1);
					sat_s1  <= 1'b0;
				end else begin
					sat_s1 <= &count_q;
					if (!(&count_q)) count_q <= count_q + OFFSET_BITS'(1);
				end
			end
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
		end
	end

	// compare the window against the aligned pattern
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) eq[i] = (win_q[i] == pa_q[i]);
	end

	assign match_all = &(~care_q | eq);
	assign len_ok    = count_q >= OFFSET_BITS'(len_eff);
	assign hit       = valid_s1 && !reported_q && len_ok && match_all;

	// offset of the first matching byte, clamped to the port width
	assign off_raw   = sat_s1 ? count_q : count_q - OFFSET_BITS'(len_eff);
	assign off_wide  = 64'(off_raw);
	assign off_clamp = (off_wide > 64'hFFFF_FFFF) ? '1 : off_wide[MATCH_OFF_W-1:0];

	// drive the result word into the queue
	always_comb begin
		res_wr.valid             = advance && (hit || (last_s1 && !reported_q));
		res_wr.data.found        = hit;
		res_wr.data.match_offset = hit ? off_clamp : '0;
	end

	// mark a reported match, drop the mark at the end of the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= 1'b0;
		end else if (advance) begin
			reported_q <= last_s1 ? 1'b0 : (reported_q | hit);
		end
	end

endmodule

/* sv/wbps_queue.sv */
// ----------------------------------------------------------------------------
// wbps_queue: result queue
// Short first-word-fall-through queue between the compare stage and the
// result port, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module wbps_queue
	import wbps_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  result_wr_t    wr,
	input  logic          pop,
	output result_t       head,
	output queue_status_t status
);

	result_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_W:0]   cnt_q;
	logic                   do_rd;

	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign do_rd        = pop && !status.empty;
	assign head         = entry_q[rd_ptr_q];

	// store the incoming word
	always_ff @(posedge clk) begin
		if (wr.valid) entry_q[wr_ptr_q] <= wr.data;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.valid) wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (do_rd)    rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			case ({wr.valid, do_rd})
				2'b10:   cnt_q <= cnt_q + (QUEUE_PTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QUEUE_PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/wildcard_byte_pattern_scan.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan: byte signature scanner with wildcard positions
// A result word is formed by the window compare in the compare stage and
// then passes through the queue before it reaches the result ports.
// Throughput: one byte per cycle unless a full queue holds the compare stage.
// Reset clears the byte count, the queue and the configuration (length 1).
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan
	import wbps_pkg::*;
#(
	parameter int MAX_PATTERN = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             image_byte,
	input  logic                   final_byte,
	output logic                   empty,
	input  logic                   pop,
	output logic                   found,
	output logic [MATCH_OFF_W-1:0] match_offset,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	result_wr_t    res_wr;
	result_t       head;
	queue_status_t q_status;

	// intake and compare
	wbps_front #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.image_byte (image_byte),
		.final_byte (final_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_status   (q_status),
		.res_wr     (res_wr)
	);

	// result queue
	wbps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.pop    (pop),
		.head   (head),
		.status (q_status)
	);

	assign empty        = q_status.empty;
	assign found        = head.found;
	assign match_offset = head.match_offset;

	// never write a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		res_wr.valid |-> !q_status.full)
		else $error("result written into a full queue");

	// an empty queue never stalls intake
	assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> !full)
		else $error("intake stalled with an empty queue");

	// a not-found word carries a zero offset
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr.valid && !res_wr.data.found) |-> (res_wr.data.match_offset == '0))
		else $error("not-found result with nonzero offset");

	// a word written into an empty queue is visible on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr.valid && q_status.empty) |=> !empty)
		else $error("written word not visible");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the wildcard byte pattern scanner
// Streams images of bytes through the push side and checks each result word
// on the pop side against a cycle-free scan model kept in the bench. Runs a
// short directed part, then random phases with a new pattern, mask and
// length each time and different amounts of idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import wbps_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam longint unsigned COUNT_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_BYTES = 125;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} image_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] image_byte = 8'h00;
	logic final_byte = 1'b0;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic full;
	logic empty;
	logic found;
	logic [MATCH_OFF_W-1:0] match_offset;

	// bench state
	image_word_t bytes_to_send[$];
	result_t scan_results_due[$];
	logic in_taken = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned pop_stall_pct = 0;
	int unsigned err_count = 0;

	// scan model: configuration and image state
	logic [63:0] pat_word[PAT_WORDS] = '{default: '0};
	logic [WILD_W-1:0] wild_mask = '0;
	logic [LEN_W-1:0] pat_len_raw = 6'd1;
	logic [7:0] window_q[PAT_BYTES] = '{default: '0};
	longint unsigned seen_cnt = 0;
	bit hit_done = 1'b0;

	wildcard_byte_pattern_scan dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.image_byte(image_byte),
		.final_byte(final_byte),
		.empty(empty),
		.pop(pop),
		.found(found),
		.match_offset(match_offset),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #1 clk = ~clk;

	initial begin
		#400000;
		$display("wildcard_byte_pattern_scan: mismatch");
		$finish;
	end

	// pattern length as the block uses it: 0 reads as 1, clamp at the top
	function automatic int unsigned used_len();
		if (pat_len_raw == 0)
			return 1;
		if (pat_len_raw > PAT_BYTES)
			return PAT_BYTES;
		return pat_len_raw;
	endfunction

	function automatic logic [7:0] pattern_byte(input int unsigned k);
		return pat_word[k >> 3][(k & 7) * 8 +: 8];
	endfunction

	// advance the window by one byte and queue the result word it causes
	function automatic void scan_byte(input logic [7:0] b, input logic last);
		int unsigned len;
		int unsigned i;
		bit was_sat;
		bit hit;
		bit got;
		longint unsigned off;
		result_t res;
		len = used_len();
		was_sat = seen_cnt >= COUNT_MAX;
		got = 1'b0;
		for (i = PAT_BYTES - 1; i > 0; i--)
			window_q[i] = window_q[i - 1];
		window_q[0] = b;
		if (!was_sat)
			seen_cnt++;
		if (!hit_done && seen_cnt >= len) begin
			hit = 1'b1;
			for (i = 0; i < len; i++) begin
				if (!wild_mask[i] && window_q[len - 1 - i] != pattern_byte(i))
					hit = 1'b0;
			end
			if (hit) begin
				off = was_sat ? COUNT_MAX : seen_cnt - len;
				if (off > 64'hFFFF_FFFF)
					off = 64'hFFFF_FFFF;
				res.found = 1'b1;
				res.match_offset = off[MATCH_OFF_W-1:0];
				scan_results_due = {scan_results_due, res};
				hit_done = 1'b1;
				got = 1'b1;
			end
		end
		if (last) begin
			if (!got && !hit_done) begin
				res.found = 1'b0;
				res.match_offset = '0;
				scan_results_due = {scan_results_due, res};
			end
			window_q = '{default: '0};
			seen_cnt = 0;
			hit_done = 1'b0;
		end
	endfunction

	task automatic report_error(input string what, input longint unsigned got,
		input longint unsigned want);
		$display("ERROR at %0t: %s: got %0h, want %0h", $realtime, what, got, want);
		err_count++;
	endtask

	// write one register and mirror it into the scan model
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_PAT_0, REG_PAT_1, REG_PAT_2, REG_PAT_3: begin
				pat_word[idx[1:0]] = data;
			end
			REG_WILDCARD: begin
				wild_mask = data[WILD_W-1:0];
			end
			REG_LENGTH: begin
				pat_len_raw = data[LEN_W-1:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_word(input logic [7:0] b, input logic last);
		image_word_t w;
		w.data = b;
		w.last = last;
		bytes_to_send = {bytes_to_send, w};
	endtask

	// hold until every byte went in and every result word came out
	task automatic wait_idle();
		while (bytes_to_send.size() != 0 || push || scan_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// queue one image: mostly with the pattern planted, some near misses, some noise
	task automatic queue_image(output int unsigned added);
		int unsigned len;
		int unsigned img_len;
		int unsigned pos;
		int unsigned kind;
		int unsigned j;
		int unsigned flip;
		logic [7:0] img[$];
		len = used_len();
		kind = $urandom_range(99);
		if ($urandom_range(9) == 0)
			img_len = $urandom_range(len, 1);
		else
			img_len = $urandom_range(len + 24, len);
		for (j = 0; j < img_len; j++) begin
			if ($urandom_range(3) == 0)
				img = {img, 8'($urandom)};
			else
				img = {img, pattern_byte($urandom_range(len - 1))};
		end
		if (kind < 80 && img_len >= len) begin
			if ($urandom_range(3) == 0)
				pos = img_len - len;
			else
				pos = $urandom_range(img_len - len);
			for (j = 0; j < len; j++)
				img[pos + j] = wild_mask[j] ? 8'($urandom) : pattern_byte(j);
			// break one byte for a near miss
			if (kind >= 60) begin
				flip = $urandom_range(len - 1);
				img[pos + flip] = img[pos + flip] ^ (8'h01 << $urandom_range(7));
			end
		end
		for (j = 0; j < img_len; j++)
			send_word(img[j], j == img_len - 1);
		added = img_len;
	endtask

	function automatic logic [63:0] pattern_word(input int ph);
		case (ph)
			2: return '1;
			4: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// load a new pattern, mask and length for one random phase
	task automatic setup_phase(input int ph);
		logic [LEN_W-1:0] len_raw;
		logic [WILD_W-1:0] mask;
		case (ph)
			0: len_raw = 6'd1;
			1: len_raw = 6'd32;
			2: len_raw = 6'd0;
			3: len_raw = 6'd63;
			4: len_raw = 6'd33;
			5: len_raw = 6'($urandom_range(6, 2));
			6: len_raw = 6'($urandom_range(32, 1));
			default: len_raw = 6'($urandom_range(12, 7));
		endcase
		case (ph)
			0, 1: mask = '0;
			2: mask = 32'h8000_0000;
			3: mask = '1;
			default: mask = $urandom & $urandom & $urandom;
		endcase
		write_reg(REG_PAT_0, pattern_word(ph));
		write_reg(REG_PAT_1, pattern_word(ph));
		write_reg(REG_PAT_2, pattern_word(ph));
		write_reg(REG_PAT_3, pattern_word(ph));
		write_reg(REG_WILDCARD, {32'($urandom), mask});
		write_reg(REG_LENGTH, {58'($urandom), len_raw});
		write_reg((ph % 2 != 0) ? REG_SPARE_7 : REG_SPARE_6, {$urandom, $urandom});
		case (ph % 4)
			0: begin
				send_idle_pct = 0;
				pop_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 81;
				pop_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				pop_stall_pct = 81;
			end
			default: begin
				send_idle_pct = 22;
				pop_stall_pct = 22;
			end
		endcase
	endtask

	// drive the push side and the pop side at the falling edge
	always @(negedge clk) begin
		logic next_push;
		if (in_taken)
			void'(bytes_to_send.pop_front());
		// hold a word that was not taken
		if (push && !in_taken)
			next_push = 1'b1;
		else
			next_push = bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct;
		push <= next_push;
		if (next_push) begin
			image_byte <= bytes_to_send[0].data;
			final_byte <= bytes_to_send[0].last;
		end
		pop <= $urandom_range(99) >= pop_stall_pct;
	end

	// sample both handshakes at the rising edge
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (scan_results_due.size() == 0) begin
					report_error("result word with none pending", {found, match_offset}, 0);
				end else begin
					want = scan_results_due.pop_front();
					if (found !== want.found)
						report_error("found", found, want.found);
					if (match_offset !== want.match_offset)
						report_error("match_offset", match_offset, want.match_offset);
				end
			end
			if (push && !full)
				scan_byte(image_byte, final_byte);
		end
		in_taken <= arst_n && push && !full;
	end

	initial begin
		int unsigned added;
		int unsigned phase_cnt;
		int ph;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: one-byte pattern 0x00
		send_word(8'hFF, 1'b0);
		send_word(8'h80, 1'b1);
		send_word(8'h00, 1'b1);
		send_word(8'h7F, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		wait_idle();

		// four-byte pattern with a wildcard in position 2
		write_reg(REG_PAT_0, 64'h0000_0000_EF55_ADDE);
		write_reg(REG_WILDCARD, 64'h4);
		write_reg(REG_LENGTH, 64'd4);
		send_word(8'hDE, 1'b0);
		send_word(8'hAD, 1'b1);
		send_word(8'h11, 1'b0);
		send_word(8'hDE, 1'b0);
		send_word(8'hAD, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hEF, 1'b1);
		send_word(8'hDE, 1'b0);
		send_word(8'hAD, 1'b0);
		send_word(8'h99, 1'b0);
		send_word(8'hEE, 1'b1);
		wait_idle();

		// length 0 reads as 1; spare indexes change nothing
		write_reg(REG_LENGTH, 64'd0);
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		send_word(8'hDE, 1'b1);
		send_word(8'hDF, 1'b1);
		wait_idle();

		for (ph = 0; ph < 8; ph++) begin
			setup_phase(ph);
			phase_cnt = 0;
			while (phase_cnt < PHASE_BYTES) begin
				queue_image(added);
				phase_cnt += added;
			end
			wait_idle();
		end

		if (err_count == 0)
			$display("wildcard_byte_pattern_scan: match");
		else
			$display("wildcard_byte_pattern_scan: mismatch");
		$finish;
	end

endmodule

/* files.f */
sv/wbps_pkg.sv
sv/wbps_front.sv
sv/wbps_queue.sv
sv/wildcard_byte_pattern_scan.sv
test/tb_top.sv
